FILE: src/uvp_pkg.sv
// Shared types, constants and the arctangent table for the baseline uv projection core.
// No dependencies; every other file in src imports this package.
package uvp_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ANGLE_BITS   = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int CORDIC_CELLS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int STEP_W       = $clog2(ATAN_ENTRIES);

    // Hour angle keeps its top min(16, ANGLE_BITS) bits
    localparam int HA_KEEP = (ANGLE_BITS < 16) ? ANGLE_BITS : 16;
    localparam int HA_DROP = 16 - HA_KEEP;

    // Input stage + cells + trig, product, sum, scale and output stages
    localparam int RESULT_LATENCY = CORDIC_CELLS + 6;

    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

    localparam logic [15:0] SOURCE_RA_RESET = 16'h0000;
    localparam logic [15:0] SIN_DEC_RESET   = 16'h0000;
    localparam logic [14:0] COS_DEC_RESET   = 15'h7FFF;

    // Configuration register indexes
    localparam logic [1:0] REG_SOURCE_RA = 2'd0;
    localparam logic [1:0] REG_SIN_DEC   = 2'd1;
    localparam logic [1:0] REG_COS_DEC   = 2'd2;

    // Quadrant codes of the hour angle
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic        [15:0] sidereal_angle;
        logic signed [31:0] baseline_x;
        logic signed [31:0] baseline_y;
        logic signed [31:0] baseline_z;
    } uvp_req_t;

    typedef struct packed {
        logic signed [31:0] u_coord;
        logic signed [31:0] v_coord;
    } uvp_result_t;

    // One CORDIC lane: rotation state (Q2.30, angle in 2^-32 turns) plus the baseline
    typedef struct packed {
        logic        [1:0]  quad;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
    } uvp_lane_t;

    // atan(2^-i) in 2^-32 turn units
    function automatic logic signed [31:0] uvp_atan(input logic [STEP_W-1:0] idx);
        logic signed [31:0] a;
        unique case (idx)
            5'd0:    a = 32'sh20000000;
            5'd1:    a = 32'sh12E4051E;
            5'd2:    a = 32'sh09FB385B;
            5'd3:    a = 32'sh051111D4;
            5'd4:    a = 32'sh028B0D43;
            5'd5:    a = 32'sh0145D7E1;
            5'd6:    a = 32'sh00A2F61E;
            5'd7:    a = 32'sh00517C55;
            5'd8:    a = 32'sh0028BE53;
            5'd9:    a = 32'sh00145F2F;
            5'd10:   a = 32'sh000A2F98;
            5'd11:   a = 32'sh000517CC;
            5'd12:   a = 32'sh00028BE6;
            5'd13:   a = 32'sh000145F3;
            5'd14:   a = 32'sh0000A2FA;
            5'd15:   a = 32'sh0000517D;
            5'd16:   a = 32'sh000028BE;
            5'd17:   a = 32'sh0000145F;
            5'd18:   a = 32'sh00000A30;
            5'd19:   a = 32'sh00000518;
            5'd20:   a = 32'sh0000028C;
            5'd21:   a = 32'sh00000146;
            5'd22:   a = 32'sh000000A3;
            5'd23:   a = 32'sh00000051;
            default: a = 32'sh00000000;
        endcase
        return a;
    endfunction

endpackage

FILE: src/uvp_cordic_cell.sv
// One rotation-mode CORDIC micro-rotation, registered.
// Depends on uvp_pkg (lane type, arctangent table).
module uvp_cordic_cell
    import uvp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [STEP_W-1:0] step,
    input  logic              in_valid,
    input  uvp_lane_t         in_lane,
    output logic              out_valid,
    output uvp_lane_t         out_lane
);

    logic      valid_reg;
    uvp_lane_t lane_reg;
    uvp_lane_t lane_next;

    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] atan_step;

    // step is tied to a constant per cell, so the shifts collapse to wiring
    assign dx        = in_lane.y >>> step;
    assign dy        = in_lane.x >>> step;
    assign atan_step = uvp_atan(step);

    always_comb
    begin
        lane_next = in_lane;
        if (!in_lane.z[31])
        begin
            lane_next.x = in_lane.x - dx;
            lane_next.y = in_lane.y + dy;
            lane_next.z = in_lane.z - atan_step;
        end
        else
        begin
            lane_next.x = in_lane.x + dx;
            lane_next.y = in_lane.y - dy;
            lane_next.z = in_lane.z + atan_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;

endmodule

FILE: src/uvp_project.sv
// Trig rounding, quadrant mapping and the multiply/accumulate pipeline forming u and v.
// Depends on uvp_pkg (lane and result types, quadrant codes).
module uvp_project
    import uvp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  uvp_lane_t          in_lane,
    input  logic signed [15:0] sin_dec,
    input  logic        [14:0] cos_dec,
    output logic               done,
    output uvp_result_t        result
);

    function automatic logic signed [15:0] sat_q15(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767)
            r = 16'sh7FFF;
        else if (v < -18'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic logic signed [15:0] q15_round(input logic signed [31:0] v);
        logic signed [32:0] t;
        logic signed [32:0] sh;
        t  = 33'(v) + 33'sd16384;
        sh = t >>> 15;
        return sat_q15(sh[17:0]);
    endfunction

    function automatic logic signed [31:0] sat_s32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Trig stage
    logic signed [15:0] c_q;
    logic signed [15:0] s_q;
    logic signed [17:0] c_ext;
    logic signed [17:0] s_ext;
    logic signed [17:0] ch_ext;
    logic signed [17:0] sh_ext;
    logic               t_valid_reg;
    logic signed [15:0] t_sh_reg;
    logic signed [15:0] t_ch_reg;
    logic signed [31:0] t_bx_reg;
    logic signed [31:0] t_by_reg;
    logic signed [31:0] t_bz_reg;

    assign c_q   = q15_round(in_lane.x);
    assign s_q   = q15_round(in_lane.y);
    assign c_ext = 18'(c_q);
    assign s_ext = 18'(s_q);

    always_comb
    begin
        unique case (in_lane.quad)
            QUAD_0:
            begin
                ch_ext = c_ext;
                sh_ext = s_ext;
            end
            QUAD_1:
            begin
                ch_ext = -s_ext;
                sh_ext = c_ext;
            end
            QUAD_2:
            begin
                ch_ext = -c_ext;
                sh_ext = -s_ext;
            end
            default:
            begin
                ch_ext = s_ext;
                sh_ext = -c_ext;
            end
        endcase
    end

    // Product stage
    logic               m_valid_reg;
    logic signed [47:0] m_xs_reg;
    logic signed [47:0] m_yc_reg;
    logic signed [47:0] m_xc_reg;
    logic signed [47:0] m_ys_reg;
    logic signed [47:0] m_zc_reg;
    logic signed [15:0] cos_dec_s;

    assign cos_dec_s = $signed({1'b0, cos_dec});

    // Sum stage
    logic               a_valid_reg;
    logic signed [48:0] a_uacc_reg;
    logic signed [48:0] a_w_reg;
    logic signed [47:0] a_zc_reg;

    // Scale stage: u finished, sin_dec * w formed
    logic               s_valid_reg;
    logic signed [31:0] s_u_reg;
    logic signed [63:0] s_sw_reg;
    logic signed [47:0] s_zc_reg;
    logic signed [49:0] u_round;
    logic signed [49:0] u_shift;
    logic signed [64:0] sw_full;

    assign u_round = 50'(a_uacc_reg) + 50'sd16384;
    assign u_shift = u_round >>> 15;
    assign sw_full = sin_dec * a_w_reg;

    // Output stage
    logic               done_reg;
    uvp_result_t        result_reg;
    logic signed [63:0] vacc;
    logic signed [63:0] v_shift;

    assign vacc    = (64'(s_zc_reg) <<< 15) + s_sw_reg + 64'sd536870912;
    assign v_shift = vacc >>> 30;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            a_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            t_valid_reg <= in_valid;
            m_valid_reg <= t_valid_reg;
            a_valid_reg <= m_valid_reg;
            s_valid_reg <= a_valid_reg;
            done_reg    <= s_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t_sh_reg   <= sat_q15(sh_ext);
        t_ch_reg   <= sat_q15(ch_ext);
        t_bx_reg   <= in_lane.bx;
        t_by_reg   <= in_lane.by;
        t_bz_reg   <= in_lane.bz;

        m_xs_reg   <= t_bx_reg * t_sh_reg;
        m_yc_reg   <= t_by_reg * t_ch_reg;
        m_xc_reg   <= t_bx_reg * t_ch_reg;
        m_ys_reg   <= t_by_reg * t_sh_reg;
        m_zc_reg   <= t_bz_reg * cos_dec_s;

        a_uacc_reg <= 49'(m_xs_reg) + 49'(m_yc_reg);
        a_w_reg    <= 49'(m_ys_reg) - 49'(m_xc_reg);
        a_zc_reg   <= m_zc_reg;

        s_u_reg    <= sat_s32(64'(u_shift));
        s_sw_reg   <= $signed(sw_full[63:0]);
        s_zc_reg   <= a_zc_reg;

        result_reg.u_coord <= s_u_reg;
        result_reg.v_coord <= sat_s32(v_shift);
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: src/baseline_uv_projection_core.sv
// Top level of the baseline uv projection core: config registers, hour-angle
// stage, the CORDIC cell chain and the projection pipeline.
// Depends on uvp_pkg, uvp_cordic_cell and uvp_project.
//
// Usage
//   Request channel: a request (sidereal angle plus baseline x, y, z) is taken
//   at a rising edge with start high and busy low. busy is high only during
//   reset and the cycle after it; from then on a request can be taken in every cycle.
//   Result channel: done pulses for one cycle with u_coord/v_coord on result.
//   The receiver cannot stall, so results are never held back or dropped.
//   Pipeline: an accepted request passes the hour-angle stage, one stage per
//   CORDIC micro-rotation, then trig rounding, products, sums, declination
//   scaling and the output register, which raises done with the result.
//   Throughput: one request per clock, set by the fully pipelined cell chain.
//   Config: cfg_wr_en writes cfg_data into register cfg_index at the edge
//   (0 source_ra, 1 sin_dec, 2 cos_dec; index 3 is ignored). Registers are
//   read live by the pipeline, so write them only while it is empty.
//   Reset: clears all valid flags and returns source_ra = 0, sin_dec = 0,
//   cos_dec = 32767.
module baseline_uv_projection_core
    import uvp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  uvp_req_t    req,
    output logic        done,
    output uvp_result_t result,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic        [15:0] source_ra_reg;
    logic signed [15:0] sin_dec_reg;
    logic        [14:0] cos_dec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_ra_reg <= SOURCE_RA_RESET;
            sin_dec_reg   <= SIN_DEC_RESET;
            cos_dec_reg   <= COS_DEC_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SOURCE_RA: source_ra_reg <= cfg_data;
                REG_SIN_DEC:   sin_dec_reg   <= cfg_data;
                REG_COS_DEC:   cos_dec_reg   <= cfg_data[14:0];
                default:       ;
            endcase
        end
    end

    // Ready rises at the clock edge after reset and stays up
    logic ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ready_reg <= 1'b0;
        else
            ready_reg <= 1'b1;
    end

    assign busy = !ready_reg;

    // ---------------------------------------------------------------
    // Hour-angle stage: ha = sidereal - ra mod one turn, then seed the
    // CORDIC with x = gain, y = 0 and the angle within the quadrant.
    // ---------------------------------------------------------------
    logic [15:0] ha;
    logic [15:0] ha_kept;
    uvp_lane_t   seed_lane;

    assign ha      = req.sidereal_angle - source_ra_reg;
    assign ha_kept = (ha >> HA_DROP) << HA_DROP;

    always_comb
    begin
        seed_lane.quad = ha_kept[15:14];
        seed_lane.x    = CORDIC_GAIN;
        seed_lane.y    = 32'sd0;
        seed_lane.z    = $signed({2'b00, ha_kept[13:0], 16'h0000});
        seed_lane.bx   = req.baseline_x;
        seed_lane.by   = req.baseline_y;
        seed_lane.bz   = req.baseline_z;
    end

    logic      chain_valid [0:CORDIC_CELLS];
    uvp_lane_t chain_lane  [0:CORDIC_CELLS];
    logic      seed_valid_reg;
    uvp_lane_t seed_lane_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_valid_reg <= 1'b0;
        else
            seed_valid_reg <= start && ready_reg;
    end

    always_ff @(posedge clk)
    begin
        seed_lane_reg <= seed_lane;
    end

    assign chain_valid[0] = seed_valid_reg;
    assign chain_lane[0]  = seed_lane_reg;

    // ---------------------------------------------------------------
    // CORDIC chain: cell i applies micro-rotation i and hands its lane on
    // ---------------------------------------------------------------
    for (genvar gi = 0; gi < CORDIC_CELLS; gi++)
    begin : g_cell
        uvp_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (STEP_W'(gi)),
            .in_valid  (chain_valid[gi]),
            .in_lane   (chain_lane[gi]),
            .out_valid (chain_valid[gi+1]),
            .out_lane  (chain_lane[gi+1])
        );
    end

    // ---------------------------------------------------------------
    // Projection onto the uv plane
    // ---------------------------------------------------------------
    uvp_project u_project (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chain_valid[CORDIC_CELLS]),
        .in_lane  (chain_lane[CORDIC_CELLS]),
        .sin_dec  (sin_dec_reg),
        .cos_dec  (cos_dec_reg),
        .done     (done),
        .result   (result)
    );

endmodule

FILE: src/uvp_checker.sv
// Port-level checks on the baseline uv projection core, bound to the top level.
// Depends on uvp_pkg (request/result types, RESULT_LATENCY).
module uvp_port_checker
    import uvp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input uvp_req_t    req,
    input logic        done,
    input uvp_result_t result
);

    // Every accepted request yields a result after the fixed latency
    a_req_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##RESULT_LATENCY done)
        else $error("accepted request produced no result");

    // No result without a request accepted the fixed latency earlier
    a_done_from_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, RESULT_LATENCY))
        else $error("result strobe without matching request");

    // Once ready, the core never goes busy again
    a_busy_stays_low: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !busy)
        else $error("busy rose after reset");

    // A zero baseline projects to the origin whatever the angles
    a_zero_baseline: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.baseline_x == 32'sd0 && req.baseline_y == 32'sd0
            && req.baseline_z == 32'sd0)
        |-> ##RESULT_LATENCY (result.u_coord == 32'sd0 && result.v_coord == 32'sd0))
        else $error("zero baseline gave nonzero uv");

endmodule

bind baseline_uv_projection_core uvp_port_checker u_uvp_checker (.*);
